### design/robin_hood_key_table_assert.svh
// assertion macros for the robin hood key table
// used by the modules that carry concurrent checks
`ifndef ROBIN_HOOD_KEY_TABLE_ASSERT_SVH
`define ROBIN_HOOD_KEY_TABLE_ASSERT_SVH

`ifndef SYNTHESIS
`define RHKT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RHKT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RHKT_ASSERT(lbl, clk, rst_n, prop, msg)
`define RHKT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### design/rhkt_pkg.sv
// shared types, codes and constants of the robin hood key table
// no dependencies
package rhkt_pkg;

  localparam int TABLE_SLOTS = 256;
  localparam int SLOT_BITS   = $clog2(TABLE_SLOTS);
  localparam int COUNT_W     = $clog2(TABLE_SLOTS + 1);
  localparam int LOAD_LIMIT  = TABLE_SLOTS * 3 / 4;

  localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;

  localparam logic [1:0] OP_FIND   = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] key;
    logic [63:0] home_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [63:0]        found_value;
    logic [COUNT_W-1:0] entry_total;
  } out_item_t;

  typedef struct packed {
    logic [63:0]          key;
    logic [SLOT_BITS-1:0] home;
    logic [63:0]          value;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HASH,
    S_LOOKUP,
    S_PLACE,
    S_ERASE,
    S_DONE
  } state_t;

endpackage

### design/robin_hood_key_table.sv
// robin hood key table top level: control sequencer, valid bits, slot ram
// depends on rhkt_pkg, rhkt_hash, rhkt_ram, robin_hood_key_table_assert.svh
//
//   channel  ports                        dir  item
//   in       in_valid in_ready in_item    in   op, key, home_value
//   out      out_valid out_ready out_item out  status, found_value, entry_total
//
// hashing forms three partial products and an xor-shift per multiply, then the slots
// are probed one after another; a remove also moves entries back until it stops,
// and every item passes through accept and result
// an insert at the load limit or an unused op code skips hashing and goes to the result
// slot contents live in one ram read one slot per cycle; valid bits are flops
// reset clears the valid bits and the count at once, no clearing pass
// the next item is taken while a result waits on out_ready
`include "robin_hood_key_table_assert.svh"

module robin_hood_key_table import rhkt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  state_t                 state_r, state_nxt;
  logic [1:0]             op_r, op_nxt;
  entry_t                 cur_r, cur_nxt;
  logic [SLOT_BITS-1:0]   slot_r, slot_nxt;
  logic [SLOT_BITS-1:0]   d_r, d_nxt;
  logic [SLOT_BITS-1:0]   gap_r, gap_nxt;
  logic [TABLE_SLOTS-1:0] used_r;
  logic [COUNT_W-1:0]     count_r, count_nxt;
  logic [1:0]             res_status_r, res_status_nxt;
  logic [63:0]            res_value_r, res_value_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_item_r, out_item_nxt;

  logic                   used_set, used_clr;
  logic                   we;
  logic [SLOT_BITS-1:0]   waddr;
  entry_t                 wdata, q;
  logic [SLOT_BITS-1:0]   qdist;
  logic                   used_here;
  logic                   hash_start, hash_done;
  logic [SLOT_BITS-1:0]   hash_home;

  rhkt_hash u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (hash_start),
    .key   (in_item.key),
    .done  (hash_done),
    .home  (hash_home)
  );

  rhkt_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (slot_nxt),
    .rdata (q)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign qdist     = slot_r - q.home;
  assign used_here = used_r[slot_r];

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    cur_nxt        = cur_r;
    slot_nxt       = slot_r;
    d_nxt          = d_r;
    gap_nxt        = gap_r;
    count_nxt      = count_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_item_nxt   = out_item_r;
    used_set       = 1'b0;
    used_clr       = 1'b0;
    we             = 1'b0;
    waddr          = slot_r;
    wdata          = cur_r;
    hash_start     = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt         = in_item.op;
          cur_nxt.key    = in_item.key;
          cur_nxt.value  = in_item.home_value;
          res_value_nxt  = 64'd0;
          res_status_nxt = ST_NOT_FOUND;
          if (in_item.op == OP_INSERT && count_r >= COUNT_W'(LOAD_LIMIT)) begin
            res_status_nxt = ST_FULL;
            state_nxt      = S_DONE;
          end else if (in_item.op == OP_FIND || in_item.op == OP_INSERT ||
                       in_item.op == OP_REMOVE) begin
            hash_start = 1'b1;
            state_nxt  = S_HASH;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_HASH: begin
        if (hash_done) begin
          cur_nxt.home = hash_home;
          slot_nxt     = hash_home;
          d_nxt        = '0;
          state_nxt    = (op_r == OP_INSERT) ? S_PLACE : S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (!used_here || qdist < d_r) begin
          state_nxt = S_DONE;
        end else if (q.key == cur_r.key) begin
          res_status_nxt = ST_OK;
          res_value_nxt  = q.value;
          if (op_r == OP_REMOVE) begin
            gap_nxt   = slot_r;
            slot_nxt  = slot_r + 1'b1;
            state_nxt = S_ERASE;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          slot_nxt = slot_r + 1'b1;
          d_nxt    = d_r + 1'b1;
        end
      end
      S_ERASE: begin
        if (!used_here || qdist == '0) begin
          used_clr  = 1'b1;
          count_nxt = count_r - 1'b1;
          state_nxt = S_DONE;
        end else begin
          we       = 1'b1;
          waddr    = gap_r;
          wdata    = q;
          gap_nxt  = slot_r;
          slot_nxt = slot_r + 1'b1;
        end
      end
      S_PLACE: begin
        if (!used_here) begin
          we             = 1'b1;
          used_set       = 1'b1;
          count_nxt      = count_r + 1'b1;
          res_status_nxt = ST_OK;
          state_nxt      = S_DONE;
        end else begin
          if (qdist < d_r) begin
            we      = 1'b1;
            cur_nxt = q;
            d_nxt   = qdist + 1'b1;
          end else begin
            d_nxt = d_r + 1'b1;
          end
          slot_nxt = slot_r + 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt            = 1'b1;
          out_item_nxt.status      = res_status_r;
          out_item_nxt.found_value = res_value_r;
          out_item_nxt.entry_total = count_r;
          state_nxt                = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (used_set) begin
        used_r[slot_r] <= 1'b1;
      end
      if (used_clr) begin
        used_r[gap_r] <= 1'b0;
      end
    end
    op_r         <= op_nxt;
    cur_r        <= cur_nxt;
    slot_r       <= slot_nxt;
    d_r          <= d_nxt;
    gap_r        <= gap_nxt;
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
    out_item_r   <= out_item_nxt;
  end

  `RHKT_ASSERT(a_count_limit, clk, rst_n, count_r <= COUNT_W'(LOAD_LIMIT), "count over load limit")
  `RHKT_ASSERT(a_count_used, clk, rst_n, count_r == COUNT_W'($countones(used_r)), "count and valid bits disagree")
  `RHKT_ASSERT(a_hash_in_state, clk, rst_n, hash_done |-> state_r == S_HASH, "hash done outside hash state")
  `RHKT_ASSERT(a_accept_next, clk, rst_n, (in_valid && in_ready) |=> (state_r == S_HASH || state_r == S_DONE), "bad state after accept")
  `RHKT_ASSERT(a_out_from_done, clk, rst_n, $rose(out_valid_r) |-> $past(state_r == S_DONE), "result not from done state")

endmodule

### design/rhkt_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module rhkt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/rhkt_hash.sv
// splitmix64 finalizer over key >> 3, one 32x32 partial product per cycle
// depends on rhkt_pkg
module rhkt_hash import rhkt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [63:0]          key,
  output logic                 done,
  output logic [SLOT_BITS-1:0] home
);

  logic        busy_r, busy_nxt;
  logic [2:0]  ph_r, ph_nxt;
  logic [63:0] v_r, v_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [63:0] x, c, prod, hfull;
  logic [31:0] a_op, c_op;

  always_comb begin
    x     = key >> 3;
    c     = ph_r[2] ? MIX_C2 : MIX_C1;
    a_op  = (ph_r[1:0] == 2'd2) ? v_r[63:32] : v_r[31:0];
    c_op  = (ph_r[1:0] == 2'd1) ? c[63:32] : c[31:0];
    prod  = a_op * c_op;
    hfull = acc_r ^ (acc_r >> 31);
    home  = hfull[SLOT_BITS-1:0];
    done  = busy_r && (ph_r == 3'd7);

    busy_nxt = busy_r;
    ph_nxt   = ph_r;
    v_nxt    = v_r;
    acc_nxt  = acc_r;
    if (start) begin
      busy_nxt = 1'b1;
      ph_nxt   = 3'd0;
      v_nxt    = x ^ (x >> 30);
    end else if (busy_r) begin
      ph_nxt = ph_r + 3'd1;
      case (ph_r[1:0])
        2'd0: acc_nxt = prod;
        2'd3: begin
          v_nxt = acc_r ^ (acc_r >> 27);
          if (ph_r[2]) begin
            busy_nxt = 1'b0;
          end
        end
        default: acc_nxt = acc_r + {prod[31:0], 32'd0};
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ph_r   <= 3'd0;
    end else begin
      busy_r <= busy_nxt;
      ph_r   <= ph_nxt;
    end
    v_r   <= v_nxt;
    acc_r <= acc_nxt;
  end

endmodule
